>>> rtl/cra_pkg.sv
// Shared types and constants for the complex register ALU.
package cra_pkg;

   localparam int PartWidth = 32;
   localparam int FullWidth = 64;

   typedef enum logic [2:0] {
      KIND_STORE    = 3'd0,
      KIND_ADD      = 3'd1,
      KIND_SUB      = 3'd2,
      KIND_MUL      = 3'd3,
      KIND_DIV      = 3'd4,
      KIND_CMP      = 3'd5,
      KIND_RSVD6    = 3'd6,
      KIND_RSVD7    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_PROD,
      ST_SUM,
      ST_SCALE,
      ST_DIVINIT,
      ST_DIVRUN,
      ST_DIVDONE,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;    // latch request fields
      logic read_ops;   // register the operand entries
      logic do_prod;    // register the six products
      logic do_sum;     // combine products into the two sums and the denominator
      logic do_scale;   // finish add/sub/mul/cmp/store result
      logic div_init;   // load the divider for the current part
      logic div_step;   // one divider iteration
      logic div_done;   // take the current divider result
      logic write_back; // update the register file, present result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      kind_type kind;
      logic     den_zero;
      logic     div_last;  // final divider iteration this cycle
      logic     div_imag;  // working on imaginary part
   } stat_type;

endpackage

>>> rtl/cra_if.sv
// Valid/ready channel interfaces for requests and responses.
interface cra_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    kind;
   logic [2:0]                    first_index;
   logic [2:0]                    second_index;
   logic [2:0]                    dest_index;
   logic signed [31:0]            real_in;
   logic signed [31:0]            imag_in;
   modport source (output valid, kind, first_index, second_index, dest_index,
                   real_in, imag_in, input ready);
   modport sink (input valid, kind, first_index, second_index, dest_index,
                 real_in, imag_in, output ready);
endinterface

interface cra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [31:0]            real_out;
   logic signed [31:0]            imag_out;
   logic                          is_equal;
   logic [1:0]                    status;
   modport source (output valid, real_out, imag_out, is_equal, status, input ready);
   modport sink (input valid, real_out, imag_out, is_equal, status, output ready);
endinterface

>>> rtl/cra_ctrl.sv
// Sequencing state machine for the complex register ALU.
module cra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cra_pkg::stat_type   stat,
   output cra_pkg::cmd_type    cmd
);

   cra_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cra_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // result register must be free before a new item enters
   assign req_ready = (state_ff == cra_pkg::ST_IDLE) && !rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         cra_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = cra_pkg::ST_READ;
            end
         end
         cra_pkg::ST_READ: begin
            cmd.read_ops = 1'b1;
            state_in     = cra_pkg::ST_PROD;
         end
         cra_pkg::ST_PROD: begin
            cmd.do_prod = 1'b1;
            state_in    = cra_pkg::ST_SUM;
         end
         cra_pkg::ST_SUM: begin
            cmd.do_sum = 1'b1;
            if (stat.kind == cra_pkg::KIND_DIV) state_in = cra_pkg::ST_DIVINIT;
            else state_in = cra_pkg::ST_SCALE;
         end
         cra_pkg::ST_SCALE: begin
            cmd.do_scale = 1'b1;
            state_in     = cra_pkg::ST_WRITE;
         end
         cra_pkg::ST_DIVINIT: begin
            if (stat.den_zero) begin
               state_in = cra_pkg::ST_WRITE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = cra_pkg::ST_DIVRUN;
            end
         end
         cra_pkg::ST_DIVRUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = cra_pkg::ST_DIVDONE;
         end
         cra_pkg::ST_DIVDONE: begin
            cmd.div_done = 1'b1;
            if (stat.div_imag) state_in = cra_pkg::ST_WRITE;
            else state_in = cra_pkg::ST_DIVINIT;
         end
         cra_pkg::ST_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = cra_pkg::ST_RESP;
         end
         cra_pkg::ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = cra_pkg::ST_IDLE;
         end
         default: state_in = cra_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> rtl/cra_datapath.sv
// Register file, product/sum stages and restoring divider.
module cra_datapath #(
   parameter int ENTRIES       = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_kind,
   input  logic [2:0]          req_first_index,
   input  logic [2:0]          req_second_index,
   input  logic [2:0]          req_dest_index,
   input  logic signed [31:0]  req_real_in,
   input  logic signed [31:0]  req_imag_in,
   input  cra_pkg::cmd_type    cmd,
   output cra_pkg::stat_type   stat,
   output logic signed [31:0]  rsp_real_out,
   output logic signed [31:0]  rsp_imag_out,
   output logic                rsp_is_equal,
   output logic [1:0]          rsp_status
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int QW = 66;                  // quotient magnitude width
   localparam int CW = $clog2(QW + 1);
   localparam int Steps = 64 + FRACTION_BITS;
   localparam logic [65:0] QCap = 66'h80000000;

   // register file with per-entry valid bits (invalid reads as zero)
   logic [63:0]        mem_ff [ENTRIES];
   logic [ENTRIES-1:0] vld_ff;

   cra_pkg::kind_type kind_ff;
   logic [IW-1:0]     i1_ff, i2_ff, id_ff;
   logic signed [31:0] rin_ff, iin_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [63:0] pac_ff, pbd_ff, pad_ff, pbc_ff, pcc_ff, pdd_ff;
   logic [63:0]        s1_ff, s2_ff, den_ff;
   logic signed [31:0] rre_ff, rim_ff;
   logic               eq_ff, sat_ff;
   logic [1:0]         st_ff;
   // divider
   logic [63:0]        num_ff;
   logic               neg_ff, imag_ff;
   logic [64:0]        rem_ff;
   logic [QW-1:0]      q_ff;
   logic [CW-1:0]      cnt_ff;
   logic               cap_ff;
   logic signed [31:0] qre_ff;
   logic signed [31:0] out_re_ff, out_im_ff;
   logic               out_eq_ff;
   logic [1:0]         out_st_ff;

   // index modulo ENTRIES by repeated compare and subtract
   function automatic logic [IW-1:0] idx(input logic [2:0] v);
      int m;
      m = int'(v);
      for (int k = 0; k < 8; k++) begin
         if (m >= ENTRIES) m = m - ENTRIES;
      end
      return IW'(m);
   endfunction

   function automatic logic [63:0] rd(input logic [63:0] e, input logic v);
      return v ? e : 64'd0;
   endfunction

   // saturate a 33-bit signed value
   function automatic logic [32:0] sat33(input logic signed [32:0] v);
      if (v > 33'sd2147483647) return {1'b1, 32'h7fffffff};
      if (v < -33'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   // floor shift of a signed 64-bit sum, saturated; 2^63 counts as positive
   function automatic logic [32:0] scl(input logic [63:0] u);
      logic signed [63:0] s;
      s = $signed(u) >>> FRACTION_BITS;
      if (u == 64'h8000000000000000) return {1'b1, 32'h7fffffff};
      if (s > 64'sd2147483647) return {1'b1, 32'h7fffffff};
      if (s < -64'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, s[31:0]};
   endfunction

   // sign magnitude to 32 bits with saturation
   function automatic logic [32:0] sgn(input logic n, input logic [QW-1:0] m);
      if (n) begin
         if (m > QCap) return {1'b1, 32'h80000000};
         return {1'b0, 32'(-m)};
      end
      if (m > QCap - 66'd1) return {1'b1, 32'h7fffffff};
      return {1'b0, m[31:0]};
   endfunction

   logic [63:0] ent1, ent2;
   logic [32:0] t_re, t_im, t_q;
   logic [64:0] rem_sh, rem_sub;
   logic        num_bit;
   logic [QW-1:0] q_nx;
   logic [63:0] mag;

   assign ent1 = rd(mem_ff[i1_ff], vld_ff[i1_ff]);
   assign ent2 = rd(mem_ff[i2_ff], vld_ff[i2_ff]);
   assign num_bit = (cnt_ff < CW'(64)) ? num_ff[63] : 1'b0;
   assign rem_sh  = {rem_ff[63:0], num_bit};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign q_nx    = rem_sub[64] ? {q_ff[QW-2:0], 1'b0} : {q_ff[QW-2:0], 1'b1};
   assign t_q     = sgn(neg_ff, cap_ff ? QCap + 66'd1 : q_ff);

   always_comb begin
      t_re = '0;
      t_im = '0;
      case (kind_ff)
         cra_pkg::KIND_ADD: begin
            t_re = sat33(33'(a_ff) + 33'(c_ff));
            t_im = sat33(33'(b_ff) + 33'(d_ff));
         end
         cra_pkg::KIND_SUB: begin
            t_re = sat33(33'(a_ff) - 33'(c_ff));
            t_im = sat33(33'(b_ff) - 33'(d_ff));
         end
         cra_pkg::KIND_MUL: begin
            t_re = scl(s1_ff);
            t_im = scl(s2_ff);
         end
         cra_pkg::KIND_STORE: t_re = {1'b0, rin_ff};
         default: ;
      endcase
   end

   // numerator magnitude of the part entering the divider
   always_comb begin
      mag = imag_ff ? s2_ff : s1_ff;
      if (mag[63] && mag != 64'h8000000000000000) mag = -mag;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (cmd.write_back && (kind_ff == cra_pkg::KIND_STORE
               || kind_ff == cra_pkg::KIND_ADD || kind_ff == cra_pkg::KIND_SUB
               || kind_ff == cra_pkg::KIND_MUL
               || (kind_ff == cra_pkg::KIND_DIV && den_ff != 64'd0)))
         vld_ff[kind_ff == cra_pkg::KIND_STORE ? i1_ff : id_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= cra_pkg::kind_type'(req_kind);
         i1_ff   <= idx(req_first_index);
         i2_ff   <= idx(req_second_index);
         id_ff   <= idx(req_dest_index);
         rin_ff  <= req_real_in;
         iin_ff  <= req_imag_in;
         imag_ff <= 1'b0;
         sat_ff  <= 1'b0;
         st_ff   <= cra_pkg::STATUS_OK;
         eq_ff   <= 1'b0;
         rre_ff  <= '0;
         rim_ff  <= '0;
      end
      if (cmd.read_ops) begin
         a_ff  <= ent1[63:32];
         b_ff  <= ent1[31:0];
         c_ff  <= ent2[63:32];
         d_ff  <= ent2[31:0];
      end
      if (cmd.do_prod) begin
         pac_ff <= a_ff * c_ff;
         pbd_ff <= b_ff * d_ff;
         pad_ff <= a_ff * d_ff;
         pbc_ff <= b_ff * c_ff;
         pcc_ff <= c_ff * c_ff;
         pdd_ff <= d_ff * d_ff;
         eq_ff  <= (kind_ff == cra_pkg::KIND_CMP) && a_ff == c_ff && b_ff == d_ff;
      end
      if (cmd.do_sum) begin
         den_ff <= 64'(pcc_ff) + 64'(pdd_ff);
         if (kind_ff == cra_pkg::KIND_DIV) begin
            s1_ff <= 64'(pac_ff) + 64'(pbd_ff);
            s2_ff <= 64'(pbc_ff) - 64'(pad_ff);
         end else begin
            s1_ff <= 64'(pac_ff) - 64'(pbd_ff);
            s2_ff <= 64'(pad_ff) + 64'(pbc_ff);
         end
      end
      if (cmd.do_scale) begin
         rre_ff <= t_re[31:0];
         rim_ff <= (kind_ff == cra_pkg::KIND_STORE) ? iin_ff : t_im[31:0];
         if (t_re[32] || t_im[32]) st_ff <= cra_pkg::STATUS_SAT;
      end
      if (cmd.div_init) begin
         num_ff <= mag;
         // a sum of exactly 2^63 is a positive value
         neg_ff <= (imag_ff ? s2_ff[63] : s1_ff[63]) && mag != 64'h8000000000000000;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= '0;
         cap_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[62:0], 1'b0};
         rem_ff <= rem_sub[64] ? rem_sh : rem_sub;
         q_ff   <= q_nx;
         cnt_ff <= cnt_ff + CW'(1);
         if (q_nx > QCap) cap_ff <= 1'b1;
      end
      if (cmd.div_done) begin
         if (t_q[32]) sat_ff <= 1'b1;
         if (imag_ff) rim_ff <= t_q[31:0];
         else qre_ff <= t_q[31:0];
         if (!imag_ff) rre_ff <= t_q[31:0];
         imag_ff <= 1'b1;
      end
      if (cmd.write_back) begin
         if (kind_ff == cra_pkg::KIND_STORE) mem_ff[i1_ff] <= {rin_ff, iin_ff};
         else if (kind_ff == cra_pkg::KIND_ADD || kind_ff == cra_pkg::KIND_SUB
                  || kind_ff == cra_pkg::KIND_MUL)
            mem_ff[id_ff] <= {rre_ff, rim_ff};
         else if (kind_ff == cra_pkg::KIND_DIV && den_ff != 64'd0)
            mem_ff[id_ff] <= {qre_ff, rim_ff};
         out_re_ff <= rre_ff;
         out_im_ff <= rim_ff;
         out_eq_ff <= eq_ff;
         if (kind_ff == cra_pkg::KIND_DIV && den_ff == 64'd0) begin
            out_st_ff <= cra_pkg::STATUS_DIV0;
            out_re_ff <= '0;
            out_im_ff <= '0;
         end else if (sat_ff) out_st_ff <= cra_pkg::STATUS_SAT;
         else out_st_ff <= st_ff;
      end
   end

   assign stat.kind     = kind_ff;
   assign stat.den_zero = (den_ff == 64'd0);
   assign stat.div_last = (cnt_ff == CW'(Steps - 1));
   assign stat.div_imag = imag_ff;

   assign rsp_real_out = out_re_ff;
   assign rsp_imag_out = out_im_ff;
   assign rsp_is_equal = out_eq_ff;
   assign rsp_status   = out_st_ff;

endmodule

>>> rtl/complex_register_alu_unit.sv
// Top level of the complex register ALU.
//
// One request channel (req_) and one response channel (rsp_), valid/ready.
// Each request transfer yields exactly one response transfer.
// Kinds: store, add, subtract, multiply, divide, compare equal.
// Store/add/subtract/multiply/compare go through the read, product, sum,
// scale, write and response states; a divide by zero goes from the sum
// state through divider init to write and response. Divide runs the
// one-bit-per-cycle restoring divider once per part instead of scale.
// One item is in flight at a time; req_ready is low from acceptance until
// the response has been transferred.
// Reset clears the whole register file to zero at once (valid bits) and
// drops any pending response.
// While rsp_ready is low the response is held and no new request enters.
module complex_register_alu_unit #(
   parameter int ENTRIES       = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   cra_req_if.sink req,
   cra_rsp_if.source rsp
);

   cra_pkg::cmd_type  cmd;
   cra_pkg::stat_type stat;

   cra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cra_datapath #(
      .ENTRIES       (ENTRIES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req.kind),
      .req_first_index  (req.first_index),
      .req_second_index (req.second_index),
      .req_dest_index   (req.dest_index),
      .req_real_in      (req.real_in),
      .req_imag_in      (req.imag_in),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_real_out     (rsp.real_out),
      .rsp_imag_out     (rsp.imag_out),
      .rsp_is_equal     (rsp.is_equal),
      .rsp_status       (rsp.status)
   );

`ifndef SYNTH
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request accepted while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.real_out))
      else $error("response dropped under stall");
   a_eq_only: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_equal |-> rsp.status == cra_pkg::STATUS_OK)
      else $error("equal flag with bad status");
`endif

endmodule
